### design/srm_pkg.sv
// ----------------------------------------------------------------------------
// srm_pkg
// Shared widths, codes, state types and inter-module structs for the
// sliding window rate meter.
// ----------------------------------------------------------------------------
package srm_pkg;

	localparam int TIME_W     = 48;
	localparam int BYTES_W    = 16;
	localparam int RATE_W     = 32;
	localparam int WIN_W      = 11;
	localparam int SCALE_W    = 20;
	localparam int CFG_DATA_W = 20;
	localparam int CFG_IDX_W  = 1;
	localparam int SLOT_W     = 32;
	localparam int TOTAL_W    = 48;
	localparam int HALF_W     = 24;
	localparam int PP_W       = HALF_W + SCALE_W;
	localparam int PROD_W     = TOTAL_W + SCALE_W;
	localparam int DIV_CNT_W  = 7;

	localparam int WINDOW_RESET = 1000;
	localparam int SCALE_RESET  = 8000;

	typedef enum logic [0:0] {
		OP_UPDATE = 1'b0,
		OP_QUERY  = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_MS  = 1'b0,
		REG_RATE_SCALE = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PREP,
		ST_EVAL,
		ST_WALK,
		ST_UPD_RD,
		ST_UPD_WR,
		ST_QRY,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		DV_IDLE,
		DV_MUL,
		DV_SUM,
		DV_DIV,
		DV_RND
	} div_state_t;

	typedef struct packed {
		logic               start;
		logic [TOTAL_W-1:0] total;
		logic [SCALE_W-1:0] scale;
		logic [TIME_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [RATE_W-1:0] rate;
	} div_rsp_t;

endpackage

### design/srm_slot_ram.sv
// ----------------------------------------------------------------------------
// srm_slot_ram
// Per-millisecond byte counters: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module srm_slot_ram #(
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [$clog2(DEPTH)-1:0]               wr_addr,
	input  logic [srm_pkg::SLOT_W-1:0]             wr_data,
	input  logic                                   rd_en,
	input  logic [$clog2(DEPTH)-1:0]               rd_addr,
	output logic [srm_pkg::SLOT_W-1:0]             rd_data
);

	logic [srm_pkg::SLOT_W-1:0] mem [DEPTH];
	logic [srm_pkg::SLOT_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### design/srm_rate_div.sv
// ----------------------------------------------------------------------------
// srm_rate_div
// Rate unit: total * scale in two partial products, restoring division one
// quotient bit per cycle, round half up and saturate to 32 bits.
// ----------------------------------------------------------------------------
module srm_rate_div (
	input  logic              clk,
	input  logic              arst_n,
	input  srm_pkg::div_req_t req,
	output srm_pkg::div_rsp_t rsp
);

	srm_pkg::div_state_t state_q, state_d;

	logic [srm_pkg::TOTAL_W-1:0]   total_q;
	logic [srm_pkg::SCALE_W-1:0]   scale_q;
	logic [srm_pkg::TIME_W-1:0]    div_q;
	logic [srm_pkg::PP_W-1:0]      pp_lo_s1;
	logic [srm_pkg::PP_W-1:0]      pp_hi_s1;
	logic [srm_pkg::PROD_W-1:0]    num_q;
	logic [srm_pkg::TIME_W-1:0]    rem_q;
	logic [srm_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          done_q;
	logic [srm_pkg::RATE_W-1:0]    rate_q;

	logic [srm_pkg::TIME_W:0]   sh;
	logic                       ge;
	logic [srm_pkg::TIME_W:0]   sh_sub;
	logic                       rnd;
	logic [srm_pkg::PROD_W:0]   q_rnd;
	logic                       last_bit;

	always_comb begin
		sh       = {rem_q, num_q[srm_pkg::PROD_W-1]};
		ge       = sh >= {1'b0, div_q};
		sh_sub   = sh - {1'b0, div_q};
		rnd      = {rem_q, 1'b0} >= {1'b0, div_q};
		q_rnd    = {1'b0, num_q} + (srm_pkg::PROD_W+1)'(rnd);
		last_bit = cnt_q == srm_pkg::DIV_CNT_W'(srm_pkg::PROD_W - 1);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			srm_pkg::DV_IDLE: if (req.start) state_d = srm_pkg::DV_MUL;
			srm_pkg::DV_MUL:  state_d = srm_pkg::DV_SUM;
			srm_pkg::DV_SUM:  state_d = srm_pkg::DV_DIV;
			srm_pkg::DV_DIV:  if (last_bit) state_d = srm_pkg::DV_RND;
			srm_pkg::DV_RND:  state_d = srm_pkg::DV_IDLE;
			default:          state_d = srm_pkg::DV_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srm_pkg::DV_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= state_q == srm_pkg::DV_RND;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			srm_pkg::DV_IDLE: begin
				total_q <= req.total;
				scale_q <= req.scale;
				div_q   <= req.divisor;
			end
			srm_pkg::DV_MUL: begin
				pp_lo_s1 <= srm_pkg::PP_W'(total_q[srm_pkg::HALF_W-1:0])
					* srm_pkg::PP_W'(scale_q);
				pp_hi_s1 <= srm_pkg::PP_W'(total_q[srm_pkg::TOTAL_W-1:srm_pkg::HALF_W])
					* srm_pkg::PP_W'(scale_q);
			end
			srm_pkg::DV_SUM: begin
				num_q <= srm_pkg::PROD_W'(pp_lo_s1)
					+ {pp_hi_s1, {srm_pkg::HALF_W{1'b0}}};
				rem_q <= '0;
				cnt_q <= '0;
			end
			srm_pkg::DV_DIV: begin
				rem_q <= ge ? sh_sub[srm_pkg::TIME_W-1:0] : sh[srm_pkg::TIME_W-1:0];
				num_q <= {num_q[srm_pkg::PROD_W-2:0], ge};
				cnt_q <= cnt_q + srm_pkg::DIV_CNT_W'(1);
			end
			srm_pkg::DV_RND: begin
				rate_q <= (|q_rnd[srm_pkg::PROD_W:srm_pkg::RATE_W]) ? '1
					: q_rnd[srm_pkg::RATE_W-1:0];
			end
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.rate = rate_q;

endmodule

### design/sliding_window_rate_meter.sv
// ----------------------------------------------------------------------------
// sliding_window_rate_meter
// Ring of per-millisecond byte counters with a running total; updates add
// bytes to the newest slot, queries report the rounded scaled rate.
// ----------------------------------------------------------------------------
// Input channel carries operation, time_ms and byte_count; an item is taken
// when in_valid is high and in_stall low. One item is worked on at a time.
// A query gives one rate item on the output channel, an update gives none.
// Per item: PREP and EVAL evaluate expiry; WALK retires one expired slot
// per cycle (slot ring RAM read, then clear); an update reads and rewrites
// the newest slot; a query skips the divider on a zero divisor, else uses
// two partial products, a 68-bit restoring divider at one bit a cycle and
// rounding. A jump past a whole window clears window_ms slots, one per cycle.
// After reset, and after every window_ms write, the RAM is cleared one entry
// a cycle, all MAX_WINDOW entries, with in_stall high; rate_scale writes are
// taken at any time.
// The rate sits in an output register; while out_stall holds it, the next
// item is still accepted and runs until its own result is ready to load.
// ----------------------------------------------------------------------------
module sliding_window_rate_meter #(
	parameter int MAX_WINDOW = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [srm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [srm_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               operation,
	input  logic [srm_pkg::TIME_W-1:0]         time_ms,
	input  logic [srm_pkg::BYTES_W-1:0]        byte_count,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [srm_pkg::RATE_W-1:0]         rate
);

	localparam int SW   = $clog2(MAX_WINDOW);
	localparam int WW   = SW + 1;
	localparam int RstW = (srm_pkg::WINDOW_RESET > MAX_WINDOW) ? MAX_WINDOW
		: srm_pkg::WINDOW_RESET;
	localparam int TW   = srm_pkg::TIME_W;

	srm_pkg::state_t state_q, state_d;

	logic [WW-1:0]                    eff_w_q;
	logic [srm_pkg::SCALE_W-1:0]      scale_q;
	logic [srm_pkg::TOTAL_W-1:0]      total_q;
	logic [SW-1:0]                    oldest_slot_q;
	logic [TW-1:0]                    oldest_stamp_q;
	srm_pkg::op_t                     op_q;
	logic [TW-1:0]                    now_q;
	logic [srm_pkg::BYTES_W-1:0]      bytes_q;
	logic [TW-1:0]                    new_oldest_q;
	logic                             early_q;
	logic                             stale_q;
	logic [WW-1:0]                    cnt_q;
	logic                             pend_s1;
	logic [SW-1:0]                    addr_s1;
	logic [SW-1:0]                    clr_addr_q;
	logic [SW-1:0]                    clr_last_q;
	logic                             clr_resume_q;
	logic [srm_pkg::RATE_W-1:0]       res_q;
	logic                             out_valid_q;
	logic [srm_pkg::RATE_W-1:0]       rate_q;

	logic                             in_take;
	logic                             win_wr;
	logic                             scale_wr;
	logic [srm_pkg::WIN_W-1:0]        cfg_win;
	logic [WW-1:0]                    cfg_eff;
	logic [WW-1:0]                    slot_inc;
	logic [SW-1:0]                    slot_next;
	logic [SW-1:0]                    newest;
	logic [TW:0]                      prep_sub;
	logic [TW:0]                      gap;
	logic                             gap_none;
	logic                             gap_far;
	logic [TW:0]                      dq;
	logic                             zero_div;
	logic [srm_pkg::SLOT_W:0]         upd_sum;
	logic [srm_pkg::SLOT_W-1:0]       upd_new;
	logic [srm_pkg::SLOT_W-1:0]       upd_add;
	logic                             walk_issue;
	logic                             out_load;
	logic                             out_take;
	srm_pkg::state_t                  act_state;

	logic                             ram_wr_en;
	logic [SW-1:0]                    ram_wr_addr;
	logic [srm_pkg::SLOT_W-1:0]       ram_wr_data;
	logic                             ram_rd_en;
	logic [SW-1:0]                    ram_rd_addr;
	logic [srm_pkg::SLOT_W-1:0]       ram_rd_data;

	srm_pkg::div_req_t                div_req;
	srm_pkg::div_rsp_t                div_rsp;

	always_comb begin
		in_take  = in_valid && !in_stall;
		win_wr   = cfg_wr_en && cfg_index == srm_pkg::REG_WINDOW_MS;
		scale_wr = cfg_wr_en && cfg_index == srm_pkg::REG_RATE_SCALE;
		cfg_win  = cfg_data[srm_pkg::WIN_W-1:0];
		if (cfg_win == '0) begin
			cfg_eff = WW'(1);
		end else if (int'(cfg_win) > MAX_WINDOW) begin
			cfg_eff = WW'(MAX_WINDOW);
		end else begin
			cfg_eff = WW'(cfg_win);
		end

		slot_inc  = {1'b0, oldest_slot_q} + WW'(1);
		slot_next = (slot_inc >= eff_w_q) ? '0 : slot_inc[SW-1:0];
		newest    = (oldest_slot_q == '0) ? SW'(eff_w_q - WW'(1))
			: oldest_slot_q - SW'(1);

		prep_sub = {1'b0, now_q} - (TW+1)'(eff_w_q);
		gap      = {1'b0, new_oldest_q} - {1'b0, oldest_stamp_q};
		gap_none = gap[TW] || gap == '0;
		gap_far  = (|gap[TW-1:WW]) || gap[WW-1:0] > eff_w_q;

		dq       = {1'b0, now_q} - {1'b0, oldest_stamp_q};
		zero_div = dq[TW] || dq == '0;

		upd_sum = {1'b0, ram_rd_data} + (srm_pkg::SLOT_W+1)'(bytes_q);
		if (upd_sum[srm_pkg::SLOT_W]) begin
			upd_new = '1;
			upd_add = ~ram_rd_data;
		end else begin
			upd_new = upd_sum[srm_pkg::SLOT_W-1:0];
			upd_add = srm_pkg::SLOT_W'(bytes_q);
		end

		walk_issue = state_q == srm_pkg::ST_WALK && cnt_q != '0;
		out_take   = out_valid_q && !out_stall;
		out_load   = state_q == srm_pkg::ST_OUT && (!out_valid_q || !out_stall);
		act_state  = (op_q == srm_pkg::OP_QUERY) ? srm_pkg::ST_QRY : srm_pkg::ST_UPD_RD;
	end

	always_comb begin
		state_d     = state_q;
		in_stall    = state_q != srm_pkg::ST_IDLE;
		ram_wr_en   = 1'b0;
		ram_wr_addr = clr_addr_q;
		ram_wr_data = '0;
		ram_rd_en   = 1'b0;
		ram_rd_addr = newest;
		div_req.start   = 1'b0;
		div_req.total   = total_q;
		div_req.scale   = scale_q;
		div_req.divisor = dq[TW-1:0];
		unique case (state_q)
			srm_pkg::ST_CLEAR: begin
				ram_wr_en = 1'b1;
				if (clr_addr_q == clr_last_q) begin
					state_d = clr_resume_q ? act_state : srm_pkg::ST_IDLE;
				end
			end
			srm_pkg::ST_IDLE: begin
				if (in_take) state_d = srm_pkg::ST_PREP;
			end
			srm_pkg::ST_PREP: state_d = srm_pkg::ST_EVAL;
			srm_pkg::ST_EVAL: begin
				priority if (op_q == srm_pkg::OP_UPDATE && stale_q) begin
					state_d = srm_pkg::ST_IDLE;
				end else if (early_q || gap_none) begin
					state_d = act_state;
				end else if (gap_far) begin
					state_d = srm_pkg::ST_CLEAR;
				end else begin
					state_d = srm_pkg::ST_WALK;
				end
			end
			srm_pkg::ST_WALK: begin
				ram_rd_en   = walk_issue;
				ram_rd_addr = oldest_slot_q;
				ram_wr_en   = pend_s1;
				ram_wr_addr = addr_s1;
				if (cnt_q == '0 && !pend_s1) state_d = act_state;
			end
			srm_pkg::ST_UPD_RD: begin
				ram_rd_en = 1'b1;
				state_d   = srm_pkg::ST_UPD_WR;
			end
			srm_pkg::ST_UPD_WR: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = newest;
				ram_wr_data = upd_new;
				state_d     = srm_pkg::ST_IDLE;
			end
			srm_pkg::ST_QRY: begin
				div_req.start = !zero_div;
				state_d       = zero_div ? srm_pkg::ST_OUT : srm_pkg::ST_DIV;
			end
			srm_pkg::ST_DIV: begin
				if (div_rsp.done) state_d = srm_pkg::ST_OUT;
			end
			srm_pkg::ST_OUT: begin
				if (out_load) state_d = srm_pkg::ST_IDLE;
			end
			default: state_d = srm_pkg::ST_IDLE;
		endcase
		if (win_wr) state_d = srm_pkg::ST_CLEAR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= srm_pkg::ST_CLEAR;
			eff_w_q        <= WW'(RstW);
			scale_q        <= srm_pkg::SCALE_W'(srm_pkg::SCALE_RESET);
			total_q        <= '0;
			oldest_slot_q  <= '0;
			oldest_stamp_q <= '0;
			cnt_q          <= '0;
			pend_s1        <= 1'b0;
			clr_addr_q     <= '0;
			clr_last_q     <= SW'(MAX_WINDOW - 1);
			clr_resume_q   <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_load || (out_valid_q && !out_take);
			pend_s1     <= walk_issue;

			if (win_wr) begin
				eff_w_q       <= cfg_eff;
				total_q       <= '0;
				oldest_slot_q <= '0;
				clr_addr_q    <= '0;
				clr_last_q    <= SW'(MAX_WINDOW - 1);
				clr_resume_q  <= 1'b0;
			end else begin
				if (state_q == srm_pkg::ST_CLEAR) begin
					clr_addr_q <= clr_addr_q + SW'(1);
				end
				if (state_q == srm_pkg::ST_EVAL
						&& !(op_q == srm_pkg::OP_UPDATE && stale_q)
						&& !early_q && !gap_none) begin
					oldest_stamp_q <= new_oldest_q;
					if (gap_far) begin
						total_q       <= '0;
						oldest_slot_q <= '0;
						clr_addr_q    <= '0;
						clr_last_q    <= SW'(eff_w_q - WW'(1));
						clr_resume_q  <= 1'b1;
					end else begin
						cnt_q <= gap[WW-1:0];
					end
				end
				if (walk_issue) begin
					cnt_q         <= cnt_q - WW'(1);
					oldest_slot_q <= slot_next;
				end
				if (pend_s1) begin
					total_q <= total_q - srm_pkg::TOTAL_W'(ram_rd_data);
				end
				if (state_q == srm_pkg::ST_UPD_WR) begin
					total_q <= total_q + srm_pkg::TOTAL_W'(upd_add);
				end
			end

			if (scale_wr) begin
				scale_q <= cfg_data[srm_pkg::SCALE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= oldest_slot_q;
		if (in_take) begin
			op_q    <= srm_pkg::op_t'(operation);
			now_q   <= time_ms;
			bytes_q <= byte_count;
		end
		if (state_q == srm_pkg::ST_PREP) begin
			new_oldest_q <= prep_sub[TW-1:0];
			early_q      <= prep_sub[TW];
			stale_q      <= now_q < oldest_stamp_q;
		end
		if (state_q == srm_pkg::ST_QRY) begin
			res_q <= (total_q != '0) ? '1 : '0;
		end
		if (state_q == srm_pkg::ST_DIV && div_rsp.done) begin
			res_q <= div_rsp.rate;
		end
		if (out_load) begin
			rate_q <= res_q;
		end
	end

	srm_slot_ram #(
		.DEPTH (MAX_WINDOW)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	srm_rate_div u_rate_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign out_valid = out_valid_q;
	assign rate      = rate_q;

endmodule
